// File: sv/sxps_pkg.sv
// ---------------------------------------------------------------------------
// sxps_pkg
// shared types and constants of the xor distance-field pixel shader
// ---------------------------------------------------------------------------
package sxps_pkg;

	localparam int unsigned FxSpan   = 2516582;
	localparam int unsigned FxHalf   = 1258291;
	localparam int unsigned FxOne    = 1048576;
	localparam int unsigned FxRadius = 1183191;
	localparam int unsigned SqrtSteps = 22;

	typedef enum logic [1:0] {
		REG_EDGE_COLOR    = 2'd0,
		REG_INSIDE_COLOR  = 2'd1,
		REG_OUTSIDE_COLOR = 2'd2,
		REG_LINE_WIDTH    = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		REGION_EDGE    = 2'd0,
		REGION_INSIDE  = 2'd1,
		REGION_OUTSIDE = 2'd2,
		REGION_NONE    = 2'd3
	} region_t;

	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  bg_blue;
		logic [7:0]  bg_green;
		logic [7:0]  bg_red;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic [1:0] region;
	} pixel_out_t;

	// classified request travelling from front to back
	typedef struct packed {
		logic        neg;
		logic [21:0] mag;
		logic [7:0]  bg_blue;
		logic [7:0]  bg_green;
		logic [7:0]  bg_red;
	} dist_req_t;

	// one restoring square-root step on a radicand, 2 bits per step
	typedef struct packed {
		logic [43:0] rem;
		logic [21:0] root;
	} sqrt_st_t;

	function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] pair);
		sqrt_st_t   r;
		logic [45:0] trial;
		logic [45:0] cur;
		cur   = {s.rem, pair};
		trial = {22'd0, s.root, 2'b01};
		if (cur >= trial) begin
			r.rem  = 44'(cur - trial);
			r.root = {s.root[20:0], 1'b1};
		end else begin
			r.rem  = cur[43:0];
			r.root = {s.root[20:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// File: sv/sxps_front.sv
// ---------------------------------------------------------------------------
// sxps_front
// maps pixels to the plane and computes the combined signed distance
// ---------------------------------------------------------------------------
module sxps_front #(
	parameter int unsigned IMG_HEIGHT = 4096,
	parameter int unsigned IMG_WIDTH  = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  sxps_pkg::pixel_in_t in_pix,
	input  logic                stall,
	output logic                out_valid,
	output sxps_pkg::dist_req_t out_req,
	output logic                busy_any
);
	localparam int unsigned HLast = (IMG_HEIGHT > 1) ? IMG_HEIGHT - 1 : 1;
	localparam int unsigned WLast = (IMG_WIDTH > 1) ? IMG_WIDTH - 1 : 1;
	localparam int unsigned NS    = sxps_pkg::SqrtSteps;
	localparam int unsigned Depth = 4 + NS + 2;

	// span split as quotient and remainder of the last index
	localparam int unsigned QW = sxps_pkg::FxSpan / WLast;
	localparam int unsigned RW = sxps_pkg::FxSpan % WLast;
	localparam int unsigned QH = sxps_pkg::FxSpan / HLast;
	localparam int unsigned RH = sxps_pkg::FxSpan % HLast;
	// reciprocals of the last index, exact for 32-bit numerators
	localparam int unsigned KW = 32 + $clog2(WLast);
	localparam int unsigned KH = 32 + $clog2(HLast);
	localparam logic [32:0] MW = 33'(((64'd1 << KW) + 64'(WLast) - 64'd1) / 64'(WLast));
	localparam logic [32:0] MH = 33'(((64'd1 << KH) + 64'(HLast) - 64'd1) / 64'(HLast));

	// stage 1: clamp, whole part and remainder numerator
	logic [15:0] rowc, colc;
	logic [23:0] qx_s1, qy_s1;
	logic [31:0] rx_s1, ry_s1;
	logic [7:0]  bgb_s1, bgg_s1, bgr_s1;
	logic [Depth-1:0] vld_q;
	logic adv;
	assign adv = !stall;
	assign busy_any = |vld_q;

	always_comb begin
		rowc = (32'(in_pix.row) > HLast) ? 16'(HLast) : 16'(in_pix.row);
		colc = (32'(in_pix.col) > WLast) ? 16'(WLast) : 16'(in_pix.col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s1 <= 24'(32'(colc) * QW);
			qy_s1 <= 24'(32'(rowc) * QH);
			rx_s1 <= 32'(colc) * RW + WLast / 2;
			ry_s1 <= 32'(rowc) * RH + HLast / 2;
			bgb_s1 <= in_pix.bg_blue;
			bgg_s1 <= in_pix.bg_green;
			bgr_s1 <= in_pix.bg_red;
		end
	end

	// stage 2: remainder over last index by reciprocal, give signed x, y
	logic signed [23:0] x_s2, y_s2;
	logic [7:0] bgb_s2, bgg_s2, bgr_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2 <= qx_s1 + 24'((66'(rx_s1) * 66'(MW)) >> KW) - 24'(sxps_pkg::FxHalf);
			y_s2 <= qy_s1 + 24'((66'(ry_s1) * 66'(MH)) >> KH) - 24'(sxps_pkg::FxHalf);
			bgb_s2 <= bgb_s1; bgg_s2 <= bgg_s1; bgr_s2 <= bgr_s1;
		end
	end

	// stage 3: square region and corner offsets
	localparam logic signed [23:0] One = 24'(sxps_pkg::FxOne);
	logic signed [23:0] x, y, sq_lin, ca, cb;
	logic sq_is_lin;
	always_comb begin
		x = x_s2; y = y_s2;
		sq_is_lin = 1'b1; sq_lin = '0; ca = '0; cb = '0;
		if (-x <= y && y <= x && -One <= y && y <= One) sq_lin = x - One;
		else if (-y <= x && x <= y && -One <= x && x <= One) sq_lin = y - One;
		else if (x <= y && y <= -x && -One <= y && y <= One) sq_lin = -One - x;
		else if (y <= x && x <= -y && -One <= x && x <= One) sq_lin = -One - y;
		else begin
			sq_is_lin = 1'b0;
			ca = (x >= One) ? x - One : x + One;
			cb = (y >= One) ? y - One : y + One;
			if (x >= One && y >= One) begin ca = x - One; cb = y - One; end
			else if (x <= -One && y >= One) begin ca = x + One; cb = y - One; end
			else if (x <= -One && y <= -One) begin ca = x + One; cb = y + One; end
			else begin ca = x - One; cb = y + One; end
		end
	end

	logic [22:0] ax_s3, ay_s3, ca_s3, cb_s3;
	logic signed [23:0] sql_s3;
	logic lin_s3;
	logic [7:0] bgb_s3, bgg_s3, bgr_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s3 <= 23'(x[23] ? -x : x);
			ay_s3 <= 23'(y[23] ? -y : y);
			ca_s3 <= 23'(ca[23] ? -ca : ca);
			cb_s3 <= 23'(cb[23] ? -cb : cb);
			sql_s3 <= sq_lin; lin_s3 <= sq_is_lin;
			bgb_s3 <= bgb_s2; bgg_s3 <= bgg_s2; bgr_s3 <= bgr_s2;
		end
	end

	// stage 4: sums of squares
	logic [43:0] r1_s4, r2_s4;
	logic signed [23:0] sql_s4;
	logic lin_s4;
	logic [7:0] bgb_s4, bgg_s4, bgr_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			r1_s4 <= 44'(ax_s3) * 44'(ax_s3) + 44'(ay_s3) * 44'(ay_s3);
			r2_s4 <= 44'(ca_s3) * 44'(ca_s3) + 44'(cb_s3) * 44'(cb_s3);
			sql_s4 <= sql_s3; lin_s4 <= lin_s3;
			bgb_s4 <= bgb_s3; bgg_s4 <= bgg_s3; bgr_s4 <= bgr_s3;
		end
	end

	// square-root pipeline, one root bit per stage for both roots
	sxps_pkg::sqrt_st_t s1_p [NS+1];
	sxps_pkg::sqrt_st_t s2_p [NS+1];
	logic [43:0] rad1_p [NS+1];
	logic [43:0] rad2_p [NS+1];
	logic signed [23:0] sql_p [NS+1];
	logic lin_p [NS+1];
	logic [23:0] bg_p [NS+1];

	assign s1_p[0] = '0;
	assign s2_p[0] = '0;
	assign rad1_p[0] = r1_s4;
	assign rad2_p[0] = r2_s4;
	assign sql_p[0] = sql_s4;
	assign lin_p[0] = lin_s4;
	assign bg_p[0] = {bgb_s4, bgg_s4, bgr_s4};

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (adv) begin
				s1_p[k+1] <= sxps_pkg::sqrt_step(s1_p[k], rad1_p[k][43:42]);
				s2_p[k+1] <= sxps_pkg::sqrt_step(s2_p[k], rad2_p[k][43:42]);
				rad1_p[k+1] <= {rad1_p[k][41:0], 2'b00};
				rad2_p[k+1] <= {rad2_p[k][41:0], 2'b00};
				sql_p[k+1] <= sql_p[k];
				lin_p[k+1] <= lin_p[k];
				bg_p[k+1] <= bg_p[k];
			end
		end
	end

	// combine: d = min(max(d1,-d2), max(-d1,d2))
	logic signed [24:0] d1, d2, m1, m2, dd;
	always_comb begin
		d1 = 25'($signed({1'b0, s1_p[NS].root})) - 25'(sxps_pkg::FxRadius);
		d2 = lin_p[NS] ? 25'(sql_p[NS]) : 25'($signed({1'b0, s2_p[NS].root}));
		m1 = (d1 > -d2) ? d1 : -d2;
		m2 = (-d1 > d2) ? -d1 : d2;
		dd = (m1 < m2) ? m1 : m2;
	end

	logic signed [24:0] d_sa;
	logic [23:0] bg_sa;
	always_ff @(posedge clk) begin
		if (adv) begin
			d_sa <= dd;
			bg_sa <= bg_p[NS];
		end
	end

	// scale: mag*(W-1)*5/49152, rounded; 49152 is 3 * 2^14
	localparam longint unsigned Scale = longint'(WLast) * 5;
	// ceil(2^32/3), exact for 30-bit numerators
	localparam logic [30:0] Div3 = 31'd1431655766;
	logic [24:0] mag;
	logic [63:0] pm;
	logic [43:0] prod_sb;
	logic neg_sb;
	logic [23:0] bg_sb;
	assign mag = d_sa[24] ? 25'(-d_sa) : 25'(d_sa);
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_sb <= 44'(mag) * 44'(Scale) + 44'd24576;
			neg_sb <= d_sa[24];
			bg_sb <= bg_sa;
		end
	end
	always_comb begin
		pm = 64'((62'(prod_sb[43:14]) * 62'(Div3)) >> 32);
		if (neg_sb) begin
			if (pm > 64'd2097152) pm = 64'd2097152;
		end else begin
			if (pm > 64'd2097151) pm = 64'd2097151;
		end
	end

	assign out_valid = vld_q[Depth-1];
	assign out_req = '{neg: neg_sb, mag: 22'(pm), bg_blue: bg_sb[23:16],
		bg_green: bg_sb[15:8], bg_red: bg_sb[7:0]};

endmodule

// File: sv/sxps_queue.sv
// ---------------------------------------------------------------------------
// sxps_queue
// short request queue between distance front and colour back end
// ---------------------------------------------------------------------------
module sxps_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sxps_pkg::dist_req_t din,
	input  logic                pop,
	output logic                not_empty,
	output logic                almost_full,
	output sxps_pkg::dist_req_t dout
);
	sxps_pkg::dist_req_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign not_empty   = cnt_q != 3'd0;
	assign almost_full = cnt_q >= 3'd3;
	assign dout        = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == 3'd4)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && cnt_q == 3'd0)) else $error("queue underflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 3'd1) else $error("count");
`endif

endmodule

// File: sv/sxps_back.sv
// ---------------------------------------------------------------------------
// sxps_back
// classifies distance into region and blends the colour
// ---------------------------------------------------------------------------
module sxps_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  sxps_pkg::dist_req_t  req,
	input  logic [31:0]          edge_color,
	input  logic [31:0]          inside_color,
	input  logic [31:0]          outside_color,
	input  logic [15:0]          line_width,
	output logic                 res_valid,
	output sxps_pkg::pixel_out_t res
);
	logic [31:0] col;
	sxps_pkg::region_t reg_c;
	always_comb begin
		priority if ({2'b0, req.mag} <= {5'd0, line_width, 3'd0}) begin
			reg_c = sxps_pkg::REGION_EDGE; col = edge_color;
		end else if (req.neg) begin
			reg_c = sxps_pkg::REGION_INSIDE; col = inside_color;
		end else begin
			reg_c = sxps_pkg::REGION_OUTSIDE; col = outside_color;
		end
	end

	// stage 1: weighted sums
	logic [16:0] sb_s1, sg_s1, sr_s1;
	logic [1:0]  reg_s1;
	logic        v_s1;
	logic [7:0]  a, na;
	assign a  = col[7:0];
	assign na = 8'd255 - a;
	always_ff @(posedge clk) begin
		sb_s1 <= 17'(req.bg_blue) * 17'(a) + 17'(col[15:8]) * 17'(na) + 17'd127;
		sg_s1 <= 17'(req.bg_green) * 17'(a) + 17'(col[23:16]) * 17'(na) + 17'd127;
		sr_s1 <= 17'(req.bg_red) * 17'(a) + 17'(col[31:24]) * 17'(na) + 17'd127;
		reg_s1 <= reg_c;
	end

	// stage 2: divide by 255 via x/255 = (x + (x>>8) + 1) >> 8 for x < 65536
	function automatic logic [7:0] div255(logic [16:0] x);
		logic [17:0] t;
		t = 18'(x) + 18'(x >> 8) + 18'd1;
		return t[15:8];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; res_valid <= 1'b0;
		end else begin
			v_s1 <= req_valid; res_valid <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		res.out_blue  <= div255(sb_s1);
		res.out_green <= div255(sg_s1);
		res.out_red   <= div255(sr_s1);
		res.region    <= reg_s1;
	end

`ifndef SYNTHESIS
	a_region_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.region != sxps_pkg::REGION_NONE) else $error("region");
	a_valid_lat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |=> ##1 res_valid) else $error("latency");
	a_sum_rng: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> sb_s1 < 17'd65153) else $error("sum range");
`endif

endmodule

// File: sv/sdf_xor_pixel_shader_top.sv
// ---------------------------------------------------------------------------
// sdf_xor_pixel_shader_top
// xor of circle and square distance fields, blended over the background
// ---------------------------------------------------------------------------
// channel  | handshake          | payload
// pixel in | start / busy       | pix_in (row, col, bg bytes)
// result   | done strobe        | pix_out (blended bytes, region)
// config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one request per clock while busy is low; the delay to the done strobe is
// set mostly by the 22-stage square-root pipeline of the front end
// the front end halts when the request queue is almost full
// results leave on a one-cycle done strobe; the receiver cannot stall
// reset clears control state and loads the register reset values
// ---------------------------------------------------------------------------
module sdf_xor_pixel_shader_top #(
	parameter int unsigned IMG_HEIGHT = 4096,
	parameter int unsigned IMG_WIDTH  = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  sxps_pkg::pixel_in_t   pix_in,
	output logic                  done,
	output sxps_pkg::pixel_out_t  pix_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);
	logic [31:0] edge_q, inside_q, outside_q;
	logic [15:0] lw_q;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q    <= 32'h0000_0000;
			inside_q  <= 32'h00FF_0000;
			outside_q <= 32'hFFFF_FF00;
			lw_q      <= 16'd80;
		end else if (cfg_valid) begin
			unique case (sxps_pkg::reg_idx_t'(cfg_index))
				sxps_pkg::REG_EDGE_COLOR:    edge_q    <= cfg_data;
				sxps_pkg::REG_INSIDE_COLOR:  inside_q  <= cfg_data;
				sxps_pkg::REG_OUTSIDE_COLOR: outside_q <= cfg_data;
				sxps_pkg::REG_LINE_WIDTH:    lw_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// front end: mapping and distances
	logic almost_full, f_valid, f_busy, q_ne;
	sxps_pkg::dist_req_t f_req, q_req;
	assign busy = almost_full;

	sxps_front #(.IMG_HEIGHT(IMG_HEIGHT), .IMG_WIDTH(IMG_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid (start && !busy),
		.in_pix   (pix_in),
		.stall    (almost_full),
		.out_valid(f_valid),
		.out_req  (f_req),
		.busy_any (f_busy)
	);

	// request queue; back end drains one per cycle
	sxps_queue u_queue (
		.clk, .arst_n,
		.push       (f_valid && !almost_full),
		.din        (f_req),
		.pop        (q_ne),
		.not_empty  (q_ne),
		.almost_full(almost_full),
		.dout       (q_req)
	);

	sxps_back u_back (
		.clk, .arst_n,
		.req_valid    (q_ne),
		.req          (q_req),
		.edge_color   (edge_q),
		.inside_color (inside_q),
		.outside_color(outside_q),
		.line_width   (lw_q),
		.res_valid    (done),
		.res          (pix_out)
	);

`ifndef SYNTHESIS
	a_busy_empty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_ne) else $error("busy with empty queue");
	a_front_idle: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid |-> f_busy) else $error("front valid without work");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(q_ne, 2)) else $error("spurious result");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the xor distance-field pixel shader
// ---------------------------------------------------------------------------
// an initial block queues pixel requests and register writes in phases
// a clocked driver presents them with random gaps and predicts each accepted
// pixel; a clocked monitor checks every done strobe against the oldest
// prediction. register writes only go out once the pipeline has drained
// ---------------------------------------------------------------------------
module tb_top;

	localparam int unsigned Width  = 4096;
	localparam int unsigned Height = 4096;
	// settle time before a register write, above the pipeline latency
	localparam int unsigned Settle = 48;

	typedef struct {
		bit                  is_cfg;
		sxps_pkg::pixel_in_t px;
		sxps_pkg::reg_idx_t  idx;
		logic [31:0]         data;
		int unsigned         gap;
	} stim_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	sxps_pkg::pixel_in_t  pix_in = '0;
	logic                 done;
	sxps_pkg::pixel_out_t pix_out;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	stim_t                pending[$];
	sxps_pkg::pixel_out_t shaded_q[$];
	int unsigned          mismatches = 0;

	// bench copy of the shader registers
	logic [31:0] edge_col = 32'h0000_0000;
	logic [31:0] in_col   = 32'h00FF_0000;
	logic [31:0] out_col  = 32'hFFFF_FF00;
	logic [15:0] lw       = 16'd80;

	sdf_xor_pixel_shader_top #(
		.IMG_HEIGHT(Height),
		.IMG_WIDTH (Width)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.pix_in   (pix_in),
		.done     (done),
		.pix_out  (pix_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// ---- prediction -------------------------------------------------------

	// pixel index to q3.20 plane coordinate, index saturated to the last one
	function automatic longint to_plane(longint idx, longint size);
		longint last;
		last = (size > 1) ? size - 1 : 1;
		if (idx > last) idx = last;
		return (idx * sxps_pkg::FxSpan + last / 2) / last - sxps_pkg::FxHalf;
	endfunction

	// floor of sqrt(a^2 + b^2), bit-serial
	function automatic longint hypot_fx(longint a, longint b);
		longint v, res, bt;
		if (a < 0) a = -a;
		if (b < 0) b = -b;
		v   = a * a + b * b;
		res = 0;
		bt  = 64'sd1 <<< 62;
		while (bt > v) bt = bt >>> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v   = v - (res + bt);
				res = (res >>> 1) + bt;
			end else begin
				res = res >>> 1;
			end
			bt = bt >>> 2;
		end
		return res;
	endfunction

	function automatic logic [7:0] mix(longint bg, longint c, longint a);
		return 8'((bg * a + c * (255 - a) + 127) / 255);
	endfunction

	function automatic sxps_pkg::pixel_out_t shade(sxps_pkg::pixel_in_t p);
		longint     x, y, one, d1, d2, d, mag, pm;
		bit         neg;
		logic [31:0] c;
		sxps_pkg::pixel_out_t o;
		one = sxps_pkg::FxOne;
		x   = to_plane(p.col, Width);
		y   = to_plane(p.row, Height);
		d1  = hypot_fx(x, y) - sxps_pkg::FxRadius;
		// square of half side one: four flat faces, then the four corner arcs
		if (-x <= y && y <= x && -one <= y && y <= one)      d2 = x - one;
		else if (-y <= x && x <= y && -one <= x && x <= one) d2 = y - one;
		else if (x <= y && y <= -x && -one <= y && y <= one) d2 = -one - x;
		else if (y <= x && x <= -y && -one <= x && x <= one) d2 = -one - y;
		else if (x >= one && y >= one)                       d2 = hypot_fx(x - one, y - one);
		else if (x <= -one && y >= one)                      d2 = hypot_fx(x + one, y - one);
		else if (x <= -one && y <= -one)                     d2 = hypot_fx(x + one, y + one);
		else                                                 d2 = hypot_fx(x - one, y + one);
		d = ((d1 > -d2) ? d1 : -d2);
		if (((-d1 > d2) ? -d1 : d2) < d) d = (-d1 > d2) ? -d1 : d2;
		neg = d < 0;
		mag = neg ? -d : d;
		pm  = (mag * (longint'(Width - 1) * 5) + 24576) / 49152;
		if (neg && pm > 2097152) pm = 2097152;
		if (!neg && pm > 2097151) pm = 2097151;
		if (pm <= longint'(lw) * 8) begin
			o.region = sxps_pkg::REGION_EDGE;
			c = edge_col;
		end else if (neg) begin
			o.region = sxps_pkg::REGION_INSIDE;
			c = in_col;
		end else begin
			o.region = sxps_pkg::REGION_OUTSIDE;
			c = out_col;
		end
		o.out_blue  = mix(p.bg_blue,  c[15:8],  c[7:0]);
		o.out_green = mix(p.bg_green, c[23:16], c[7:0]);
		o.out_red   = mix(p.bg_red,   c[31:24], c[7:0]);
		return o;
	endfunction

	// ---- driver -----------------------------------------------------------

	int unsigned gap_left = 0;
	int unsigned quiet = 0;

	always @(posedge clk) begin
		logic  nxt_start, nxt_cfg;
		stim_t s;
		if (arst_n) begin
			nxt_start = start;
			nxt_cfg   = cfg_valid;
			quiet     = done ? 0 : quiet + 1;
			if (start && !busy) begin
				shaded_q.push_back(shade(pix_in));
				nxt_start = 1'b0;
				quiet     = 0;
			end
			if (cfg_valid && cfg_ready) begin
				case (sxps_pkg::reg_idx_t'(cfg_index))
					sxps_pkg::REG_EDGE_COLOR:    edge_col = cfg_data;
					sxps_pkg::REG_INSIDE_COLOR:  in_col   = cfg_data;
					sxps_pkg::REG_OUTSIDE_COLOR: out_col  = cfg_data;
					sxps_pkg::REG_LINE_WIDTH:    lw       = cfg_data[15:0];
				endcase
				nxt_cfg = 1'b0;
			end
			if (!nxt_start && !nxt_cfg && pending.size() != 0) begin
				if (gap_left != 0) begin
					gap_left--;
				end else begin
					s = pending[0];
					if (!s.is_cfg) begin
						pix_in    <= s.px;
						nxt_start = 1'b1;
						gap_left  = s.gap;
						void'(pending.pop_front());
					end else if (shaded_q.size() == 0 && quiet >= Settle) begin
						// registers only change with the pipeline drained
						cfg_index <= s.idx;
						cfg_data  <= s.data;
						nxt_cfg   = 1'b1;
						void'(pending.pop_front());
					end
				end
			end
			start     <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	// ---- monitor ----------------------------------------------------------

	task automatic report(string what, int unsigned got, int unsigned want);
		$display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		sxps_pkg::pixel_out_t want;
		if (arst_n && done) begin
			if (shaded_q.size() == 0) begin
				report("result with no request waiting", pix_out, 0);
			end else begin
				want = shaded_q.pop_front();
				if (pix_out.region !== want.region)
					report("region", pix_out.region, want.region);
				if (pix_out.out_blue !== want.out_blue)
					report("blue", pix_out.out_blue, want.out_blue);
				if (pix_out.out_green !== want.out_green)
					report("green", pix_out.out_green, want.out_green);
				if (pix_out.out_red !== want.out_red)
					report("red", pix_out.out_red, want.out_red);
			end
		end
	end

	// ---- stimulus ---------------------------------------------------------

	bit burst = 0;

	task automatic add_pixel(int unsigned r, int unsigned c, int unsigned b, int unsigned g,
			int unsigned rd);
		stim_t s;
		s.is_cfg = 0;
		s.px     = '{row: 12'(r), col: 12'(c), bg_blue: 8'(b), bg_green: 8'(g), bg_red: 8'(rd)};
		s.idx    = sxps_pkg::REG_EDGE_COLOR;
		s.data   = '0;
		s.gap    = burst ? 0 : $urandom_range(0, 19);
		pending.push_back(s);
	endtask

	task automatic add_write(sxps_pkg::reg_idx_t idx, logic [31:0] data);
		stim_t s;
		s.is_cfg = 1;
		s.px     = '0;
		s.idx    = idx;
		s.data   = data;
		s.gap    = 0;
		pending.push_back(s);
	endtask

	function automatic logic [31:0] pick_colour();
		case ($urandom_range(0, 5))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return {$urandom_range(0, 32'hFFFFFF) << 8} | 32'h00;
			3:       return {$urandom_range(0, 32'hFFFFFF) << 8} | 32'hFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int unsigned lwv;
		// reset values first: corners, centre, square faces, byte extremes
		add_pixel(0, 0, 0, 0, 0);
		add_pixel(4095, 4095, 255, 255, 255);
		add_pixel(0, 4095, 255, 0, 255);
		add_pixel(4095, 0, 0, 255, 0);
		add_pixel(2047, 2047, 128, 64, 32);
		add_pixel(2048, 2048, 1, 2, 3);
		add_pixel(2047, 3754, 200, 100, 50);
		add_pixel(2047, 3753, 10, 20, 30);
		add_pixel(2047, 341, 255, 255, 0);
		add_pixel(2047, 342, 0, 0, 255);
		add_pixel(3754, 3754, 77, 88, 99);
		add_pixel(341, 341, 99, 88, 77);
		add_pixel(3900, 200, 170, 85, 170);
		add_pixel(2047, 3665, 85, 170, 85);
		add_pixel(2047, 3666, 33, 44, 55);
		add_pixel(2730, 1364, 255, 0, 0);
		// zero line width, opaque and clear colours
		add_write(sxps_pkg::REG_LINE_WIDTH, 32'd0);
		add_write(sxps_pkg::REG_EDGE_COLOR, 32'hFFFF_FFFF);
		add_write(sxps_pkg::REG_INSIDE_COLOR, 32'h1234_5600);
		add_write(sxps_pkg::REG_OUTSIDE_COLOR, 32'h0000_00FF);
		add_pixel(2047, 2047, 255, 255, 255);
		add_pixel(0, 0, 0, 0, 0);
		add_pixel(2047, 3754, 40, 50, 60);
		// widest line: everything is edge
		add_write(sxps_pkg::REG_LINE_WIDTH, 32'hFFFF);
		add_pixel(0, 0, 9, 8, 7);
		add_pixel(4095, 2047, 255, 0, 255);
		for (int ph = 0; ph < 8; ph++) begin
			lwv = (ph == 0) ? 65535 : (ph == 1) ? 0 : $urandom_range(0, 600);
			add_write(sxps_pkg::REG_EDGE_COLOR, pick_colour());
			add_write(sxps_pkg::REG_INSIDE_COLOR, pick_colour());
			add_write(sxps_pkg::REG_OUTSIDE_COLOR, pick_colour());
			add_write(sxps_pkg::REG_LINE_WIDTH, lwv);
			for (int i = 0; i < 240; i++) begin
				if (i % 60 == 0) burst = $urandom_range(0, 2) == 0;
				add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			end
		end
		burst = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0 || shaded_q.size() != 0 || start || cfg_valid)
			@(posedge clk);
		repeat (Settle) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
sv/sxps_pkg.sv
sv/sxps_front.sv
sv/sxps_queue.sv
sv/sxps_back.sv
sv/sdf_xor_pixel_shader_top.sv
dv/tb_top.sv
